// File: hw/rtl/aled_pkg.sv
// package for the addressable led frame driver
// holds word types, op/status/register codes, state encoding and the color scaler
// no dependencies
`default_nettype none

package aled_pkg;

  localparam int MaxLedsDefault     = 256;
  localparam int BytesPerLedDefault = 3;

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_SET_ALL   = 2'd1,
    OP_SHOW      = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BUSY      = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_LEDS = 2'd0,
    REG_BRIGHTNESS  = 2'd1,
    REG_SHORT_TICKS = 2'd2,
    REG_LONG_TICKS  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_FILL  = 2'd1,
    S_RUN   = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       line_level;
    logic       sending;
  } result_t;

  // (c * b) / 255 without a divider, exact over the 16-bit product range
  function automatic logic [7:0] scale_color(input logic [7:0] c, input logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] acc;
    prod = c * b;
    acc  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return acc[15:8];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aled_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module aled_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/addressable_led_frame_driver.sv
// addressable led frame driver: pixel ram, fill/clear sweep, bit timing on tick words
// depends on aled_pkg and aled_ram
// result: an accepted item's result word is in the output register in the next cycle
// throughput: one item per cycle while running and results are not stalled; set all
//   holds off items while the ram write port sweeps min(active_leds, MAX_LEDS) entries
// reset: registers to their reset values, then a clearing pass through all MAX_LEDS entries
//   of the pixel ram during which no item is taken; config writes are always taken
`default_nettype none

module addressable_led_frame_driver
  import aled_pkg::*;
#(
  parameter int MAX_LEDS      = MaxLedsDefault,
  parameter int BYTES_PER_LED = BytesPerLedDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1) + 1;
  localparam int BITS_PER_LED = BYTES_PER_LED * 8;

  logic [7:0]  active_leds;
  logic [7:0]  brightness;
  logic [15:0] short_ticks;
  logic [15:0] long_ticks;

  state_t      state, state_next;
  logic [CW-1:0] fill_idx, fill_idx_next;
  logic [CW-1:0] fill_end, fill_end_next;
  logic [23:0] fill_word, fill_word_next;

  logic [7:0]  send_led, send_led_next;
  logic [4:0]  send_bit, send_bit_next;
  logic [15:0] phase_count, phase_count_next;
  logic        high_phase, high_phase_next;
  logic        busy, busy_next;

  result_t     result_next;
  logic        can_load;
  logic        accept;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [23:0]   wr_data;
  logic [23:0]   pix;

  logic [23:0] scaled;
  logic        beyond;
  logic        cur_bit;
  logic [15:0] dur_sel, dur;
  logic [16:0] cnt_inc;
  logic [5:0]  bit_inc;
  logic        bad_index;

  aled_ram #(
    .WIDTH(24),
    .DEPTH(MAX_LEDS)
  ) u_pixels (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (AW'(send_led_next)),
    .rd_data (pix)
  );

  assign cfg_ready  = 1'b1;
  assign can_load   = !result_valid || !result_stall;
  assign item_stall = !(state == S_RUN && can_load);
  assign accept     = item_valid && !item_stall;

  assign scaled = {scale_color(item.green, brightness),
                   scale_color(item.red, brightness),
                   scale_color(item.blue, brightness)};

  // ram data always belongs to the current send_led, no writes happen during a frame
  assign beyond  = 32'(send_led) >= 32'(MAX_LEDS);
  assign cur_bit = (beyond || send_bit >= 5'd24) ? 1'b0 : pix[5'd23 - send_bit];
  assign dur_sel = high_phase ? (cur_bit ? long_ticks : short_ticks)
                              : (cur_bit ? short_ticks : long_ticks);
  assign dur     = (dur_sel == 16'd0) ? 16'd1 : dur_sel;
  assign cnt_inc = {1'b0, phase_count} + 17'd1;
  assign bit_inc = {1'b0, send_bit} + 6'd1;
  assign bad_index = (item.index >= active_leds) || (32'(item.index) >= 32'(MAX_LEDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      active_leds <= 8'd1;
      brightness  <= 8'd50;
      short_ticks <= 16'd14;
      long_ticks  <= 16'd52;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_ACTIVE_LEDS: active_leds <= cfg_data[7:0];
        REG_BRIGHTNESS:  brightness  <= cfg_data[7:0];
        REG_SHORT_TICKS: short_ticks <= cfg_data;
        REG_LONG_TICKS:  long_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      fill_idx     <= '0;
      fill_end     <= CW'(MAX_LEDS);
      fill_word    <= '0;
      send_led     <= '0;
      send_bit     <= '0;
      phase_count  <= '0;
      high_phase   <= 1'b0;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      fill_idx    <= fill_idx_next;
      fill_end    <= fill_end_next;
      fill_word   <= fill_word_next;
      send_led    <= send_led_next;
      send_bit    <= send_bit_next;
      phase_count <= phase_count_next;
      high_phase  <= high_phase_next;
      busy        <= busy_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  always_comb begin
    state_next       = state;
    fill_idx_next    = fill_idx;
    fill_end_next    = fill_end;
    fill_word_next   = fill_word;
    send_led_next    = send_led;
    send_bit_next    = send_bit;
    phase_count_next = phase_count;
    high_phase_next  = high_phase;
    busy_next        = busy;
    wr_en            = 1'b0;
    wr_addr          = AW'(fill_idx);
    wr_data          = fill_word;
    result_next      = '{status: ST_OK, line_level: 1'b0, sending: busy};

    unique case (state)
      S_CLEAR, S_FILL: begin
        if (fill_idx == fill_end) begin
          state_next = S_RUN;
        end else begin
          wr_en         = 1'b1;
          fill_idx_next = fill_idx + CW'(1);
        end
      end
      S_RUN: begin
        if (accept) begin
          if (op_t'(item.op) == OP_TICK) begin
            if (busy) begin
              result_next.line_level = high_phase;
              phase_count_next = cnt_inc[15:0];
              if (cnt_inc >= {1'b0, dur}) begin
                phase_count_next = '0;
                if (high_phase) begin
                  high_phase_next = 1'b0;
                end else begin
                  high_phase_next = 1'b1;
                  if (bit_inc >= 6'(BITS_PER_LED)) begin
                    send_bit_next = '0;
                    send_led_next = send_led + 8'd1;
                  end else begin
                    send_bit_next = bit_inc[4:0];
                  end
                end
              end
              if (send_led_next >= active_leds) begin
                busy_next        = 1'b0;
                high_phase_next  = 1'b0;
                phase_count_next = '0;
                send_bit_next    = '0;
                send_led_next    = '0;
              end
            end
          end else if (busy) begin
            result_next.status = ST_BUSY;
          end else begin
            unique case (op_t'(item.op))
              OP_SET_PIXEL: begin
                if (bad_index) begin
                  result_next.status = ST_BAD_INDEX;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(item.index);
                  wr_data = scaled;
                end
              end
              OP_SET_ALL: begin
                state_next     = S_FILL;
                fill_idx_next  = '0;
                fill_word_next = scaled;
                if (32'(active_leds) >= 32'(MAX_LEDS)) begin
                  fill_end_next = CW'(MAX_LEDS);
                end else begin
                  fill_end_next = CW'(active_leds);
                end
              end
              OP_SHOW: begin
                if (active_leds != 8'd0) begin
                  busy_next        = 1'b1;
                  send_led_next    = '0;
                  send_bit_next    = '0;
                  phase_count_next = '0;
                  high_phase_next  = 1'b1;
                end
              end
              default: ;
            endcase
            result_next.sending = busy_next;
          end
        end
      end
      default: state_next = S_RUN;
    endcase
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!high_phase && phase_count == 16'd0 && send_bit == 5'd0 && send_led == 8'd0))
    else $error("frame counters not cleared while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (6'(send_bit) < 6'(BITS_PER_LED)))
    else $error("bit counter past end of led");

  a_sweep_holds: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> item_stall)
    else $error("item taken during ram sweep");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> result_valid)
    else $error("accepted word produced no result");

  a_high_needs_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.line_level && !result.sending))
    else $error("line high outside a frame");

  a_no_write_in_frame: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("pixel ram written during a frame");
`endif

endmodule

`default_nettype wire
